// ===== sv/rotation_matrix_to_quaternion_core_macros.svh =====
// Assertion macros for the rotation matrix to quaternion core.
// No dependencies; included by the top level only.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rmq_pkg.sv =====
// Shared constants, types and width helpers for the quaternion core.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int ELEM_W        = 16;            // matrix element width
    localparam int QMAG_W        = 15;            // magnitude width (quat_w)
    localparam int QXYZ_W        = 16;            // signed component width
    localparam int ROOT_MAX      = (1 << QMAG_W) - 1;
    localparam int FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LANES         = 4;

    // lane order inside the queue word
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } rmq_sign_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rmq_q_stat_t;

    // signed width that holds one plus or minus three elements
    function automatic int sum_width(int frac);
        return ((frac > ELEM_W + 1) ? frac : ELEM_W + 1) + 3;
    endfunction

    // root bits needed for the positive sum shifted by frac - 2
    function automatic int root_width(int frac);
        return (sum_width(frac) - 1 + frac - 2 + 1) / 2;
    endfunction

endpackage

// ===== sv/rmq_front.sv =====
// Front end: forms the four clamped diagonal sums as radicands and the
// three off-diagonal sign flags. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic signed [rmq_pkg::ELEM_W-1:0] r00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r22,
    output logic [rmq_pkg::LANES*2*rmq_pkg::root_width(FRAC_BITS)+2:0] q_word
);
    import rmq_pkg::*;

    localparam int SUM_W  = sum_width(FRAC_BITS);
    localparam int RAD_E  = 2 * root_width(FRAC_BITS);
    localparam int DIFF_W = ELEM_W + 1;
    localparam int SHIFT  = FRAC_BITS - 2;

    logic signed [SUM_W-1:0]  one_s;
    logic signed [SUM_W-1:0]  e00, e11, e22;
    logic signed [SUM_W-1:0]  sum [LANES];
    logic [RAD_E-1:0]         rad [LANES];
    logic signed [DIFF_W-1:0] dx, dy, dz;
    rmq_sign_t                sgn;

    always_comb
    begin
        one_s = SUM_W'(1) <<< FRAC_BITS;
        e00   = SUM_W'(r00);
        e11   = SUM_W'(r11);
        e22   = SUM_W'(r22);
        sum[LANE_W] = one_s + e00 + e11 + e22;
        sum[LANE_X] = one_s + e00 - e11 - e22;
        sum[LANE_Y] = one_s - e00 + e11 - e22;
        sum[LANE_Z] = one_s - e00 - e11 + e22;
        for (int l = 0; l < LANES; l++)
        begin
            // non-positive sums clamp to a zero root
            if (!sum[l][SUM_W-1] && (sum[l] != '0))
                rad[l] = RAD_E'(sum[l][SUM_W-2:0]) << SHIFT;
            else
                rad[l] = '0;
        end
        dx = DIFF_W'(r21) - DIFF_W'(r12);
        dy = DIFF_W'(r02) - DIFF_W'(r20);
        dz = DIFF_W'(r10) - DIFF_W'(r01);
        sgn.neg_x = dx[DIFF_W-1];
        sgn.neg_y = dy[DIFF_W-1];
        sgn.neg_z = dz[DIFF_W-1];
        q_word = {sgn, rad[LANE_Z], rad[LANE_Y], rad[LANE_X], rad[LANE_W]};
    end

endmodule

// ===== sv/rmq_fifo.sv =====
// Short request queue between front and back end.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output rmq_pkg::rmq_q_stat_t stat
);
    import rmq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    always_comb
    begin
        do_pop      = pop && (cnt_reg != '0);
        do_push     = push && (cnt_reg != (PTR_W+1)'(DEPTH));
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== sv/rmq_back.sv =====
// Back end: four-lane pipelined integer square root, one root bit per
// stage, then saturation, sign and the result register. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  logic [rmq_pkg::LANES*2*rmq_pkg::root_width(FRAC_BITS)+2:0] q_word,
    output logic done,
    output logic        [rmq_pkg::QMAG_W-1:0] quat_w,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_x,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_y,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_z
);
    import rmq_pkg::*;

    localparam int ROOT_W = root_width(FRAC_BITS);
    localparam int RAD_E  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CMP_W  = (ROOT_W > QMAG_W) ? ROOT_W : QMAG_W;

    logic [RAD_E-1:0]  q_rad [LANES];
    rmq_sign_t         q_sgn;

    logic              vld_reg  [1:ROOT_W];
    rmq_sign_t         sgn_reg  [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [1:ROOT_W][LANES];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W][LANES];
    logic [RAD_E-1:0]  rad_reg  [1:ROOT_W][LANES];

    logic [QMAG_W-1:0] mag [LANES];
    logic [CMP_W-1:0]  root_ext [LANES];

    logic                     done_reg;
    logic [QMAG_W-1:0]        quat_w_reg;
    logic signed [QXYZ_W-1:0] quat_x_reg, quat_y_reg, quat_z_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            q_rad[l] = q_word[l*RAD_E +: RAD_E];
        q_sgn = q_word[LANES*RAD_E +: $bits(rmq_sign_t)];
    end

    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_stage
        logic              vld_p;
        rmq_sign_t         sgn_p;
        logic [REM_W-1:0]  rem_p  [LANES];
        logic [ROOT_W-1:0] root_p [LANES];
        logic [RAD_E-1:0]  rad_p  [LANES];

        if (k == 1)
        begin : g_src
            assign vld_p = q_valid;
            assign sgn_p = q_sgn;
            for (genvar l = 0; l < LANES; l++)
            begin : g_ln
                assign rem_p[l]  = '0;
                assign root_p[l] = '0;
                assign rad_p[l]  = q_rad[l];
            end
        end
        else
        begin : g_src
            assign vld_p = vld_reg[k-1];
            assign sgn_p = sgn_reg[k-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_ln
                assign rem_p[l]  = rem_reg[k-1][l];
                assign root_p[l] = root_reg[k-1][l];
                assign rad_p[l]  = rad_reg[k-1][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            sgn_reg[k] <= sgn_p;
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [REM_W-1:0] rem_in;
            logic [REM_W-1:0] trial;

            // bring down the next two radicand bits, try root*4+1
            assign rem_in = {rem_p[l][REM_W-3:0], rad_p[l][RAD_E-1 -: 2]};
            assign trial  = {root_p[l], 2'b01};

            always_ff @(posedge clk)
            begin
                rad_reg[k][l] <= rad_p[l] << 2;
                if (rem_in >= trial)
                begin
                    rem_reg[k][l]  <= rem_in - trial;
                    root_reg[k][l] <= {root_p[l][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k][l]  <= rem_in;
                    root_reg[k][l] <= {root_p[l][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root_ext[l] = CMP_W'(root_reg[ROOT_W][l]);
            mag[l] = (root_ext[l] > CMP_W'(ROOT_MAX)) ? QMAG_W'(ROOT_MAX)
                                                      : root_ext[l][QMAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        quat_w_reg <= mag[LANE_W];
        quat_x_reg <= sgn_reg[ROOT_W].neg_x ? -QXYZ_W'(mag[LANE_X]) : QXYZ_W'(mag[LANE_X]);
        quat_y_reg <= sgn_reg[ROOT_W].neg_y ? -QXYZ_W'(mag[LANE_Y]) : QXYZ_W'(mag[LANE_Y]);
        quat_z_reg <= sgn_reg[ROOT_W].neg_z ? -QXYZ_W'(mag[LANE_Z]) : QXYZ_W'(mag[LANE_Z]);
    end

    assign done   = done_reg;
    assign quat_w = quat_w_reg;
    assign quat_x = quat_x_reg;
    assign quat_y = quat_y_reg;
    assign quat_z = quat_z_reg;

endmodule

// ===== sv/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to quaternion core, top level: front end, request queue
// and pipelined square-root back end. Depends on rmq_pkg, rmq_front,
// rmq_fifo, rmq_back and the assertion macro header.
`timescale 1ns / 1ps

// One request (a 3x3 rotation matrix, signed Q1.FRAC_BITS elements) is taken
// at every clock edge with start high and busy low; a new request may come
// every cycle. The result is shown for exactly one cycle with done high,
// in request order, after it has passed the request queue and then the
// square-root pipeline, which resolves one root bit per stage for all four
// components in parallel, plus the output register. The receiver cannot
// stall the core: the back end never holds, so the short queue between the
// front and back ends never fills and busy stays low in operation.
// quat_w is the unsigned half root of 1 + trace; quat_x, quat_y and quat_z
// carry the sign of r21 - r12, r02 - r20 and r10 - r01 (zero counts as
// positive). Roots are truncated and saturated to 32767 before the sign.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r22,
    output logic done,
    output logic        [rmq_pkg::QMAG_W-1:0] quat_w,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_x,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_y,
    output logic signed [rmq_pkg::QXYZ_W-1:0] quat_z
);
    import rmq_pkg::*;
    `include "rotation_matrix_to_quaternion_core_macros.svh"

    localparam int ROOT_W = root_width(FRAC_BITS);
    localparam int Q_W    = LANES * 2 * ROOT_W + $bits(rmq_sign_t);
    localparam int LAT    = ROOT_W + 2;   // accept edge to done sample

    logic [Q_W-1:0] front_word;
    logic [Q_W-1:0] back_word;
    rmq_q_stat_t    q_stat;
    logic           accept;

    // a request is taken whenever the queue has room
    assign busy   = q_stat.full;
    assign accept = start && !busy;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .r00    (r00),
        .r01    (r01),
        .r02    (r02),
        .r10    (r10),
        .r11    (r11),
        .r12    (r12),
        .r20    (r20),
        .r21    (r21),
        .r22    (r22),
        .q_word (front_word)
    );

    // back end drains one entry per cycle whenever one is waiting
    rmq_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (front_word),
        .pop     (!q_stat.empty),
        .rd_data (back_word),
        .stat    (q_stat)
    );

    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_stat.empty),
        .q_word  (back_word),
        .done    (done),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z)
    );

    // the queue never backs up since the back end never stalls
    `RMQ_ASSERT_IMP(a_never_busy, clk, rst_n, start, !busy, "request refused by full queue")
    // every request yields a result after the fixed latency
    `RMQ_ASSERT_IMP(a_req_done, clk, rst_n, $past(accept && rst_n, LAT), done, "result missing")
    // every result traces back to exactly one request
    `RMQ_ASSERT_IMP(a_done_req, clk, rst_n, done, $past(accept && rst_n, LAT), "spurious result")
    // an empty queue that takes nothing cannot be full in the next cycle
    `RMQ_ASSERT_NXT(a_idle_quiet, clk, rst_n, q_stat.empty && !accept && !done, !q_stat.full,
        "queue filled while idle")

endmodule

// ===== dv/tb_rotation_matrix_to_quaternion_core.sv =====
// Testbench for rotation_matrix_to_quaternion_core: directed and random matrices,
// each result checked against an in-bench quaternion predictor.
// Depends on rmq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_core;

    import rmq_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int ONE_Q     = 1 << FRAC;       // 1.0 in Q1.14
    localparam int N_RANDOM  = 950;
    localparam int DRAIN_CYC = 40;              // outlasts the pipeline at FRAC = 14
    localparam int MAX_SHOWN = 10;

    // one request: nine elements, index 3*row + col
    typedef logic [8:0][ELEM_W-1:0] matrix_t;

    // one result, raw bits as they leave the core
    typedef struct packed {
        logic [QMAG_W-1:0] w;
        logic [QXYZ_W-1:0] x;
        logic [QXYZ_W-1:0] y;
        logic [QXYZ_W-1:0] z;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic signed [ELEM_W-1:0] r00 = '0, r01 = '0, r02 = '0;
    logic signed [ELEM_W-1:0] r10 = '0, r11 = '0, r12 = '0;
    logic signed [ELEM_W-1:0] r20 = '0, r21 = '0, r22 = '0;
    logic        [QMAG_W-1:0] quat_w;
    logic signed [QXYZ_W-1:0] quat_x, quat_y, quat_z;

    // requests waiting to be driven, and quaternions predicted for taken requests
    matrix_t matrix_backlog[$];
    quat_t   predicted_quats[$];

    int total_requests = 0;
    int directed_cnt = 0;
    int rotation_cnt = 0;
    int inrange_cnt = 0;
    int noise_cnt = 0;
    int taken_cnt = 0;
    int checked_cnt = 0;
    int mismatches = 0;

    rotation_matrix_to_quaternion_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .r00    (r00),
        .r01    (r01),
        .r02    (r02),
        .r10    (r10),
        .r11    (r11),
        .r12    (r12),
        .r20    (r20),
        .r21    (r21),
        .r22    (r22),
        .done   (done),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(sqrt(sum << (FRAC - 2))) for a positive sum, else zero;
    // saturated to the largest 15-bit magnitude
    function automatic longint half_root(longint sum);
        longint n;
        longint root;
        longint trial;
        if (sum <= 0)
            return 0;
        n = sum << (FRAC - 2);
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return (root > ROOT_MAX) ? longint'(ROOT_MAX) : root;
    endfunction

    // a zero difference keeps the positive sign; -0 is plain zero
    function automatic logic [QXYZ_W-1:0] signed_part(longint mag, longint diff);
        logic [QXYZ_W-1:0] v;
        v = mag[QXYZ_W-1:0];
        if (diff < 0)
            v = -v;
        return v;
    endfunction

    function automatic quat_t predict_quat(matrix_t m);
        longint a [9];
        quat_t  q;
        for (int i = 0; i < 9; i++)
            a[i] = longint'($signed(m[i]));
        q.w = QMAG_W'(half_root(ONE_Q + a[0] + a[4] + a[8]));
        q.x = signed_part(half_root(ONE_Q + a[0] - a[4] - a[8]), a[7] - a[5]);
        q.y = signed_part(half_root(ONE_Q - a[0] + a[4] - a[8]), a[2] - a[6]);
        q.z = signed_part(half_root(ONE_Q - a[0] - a[4] + a[8]), a[3] - a[1]);
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic matrix_t mk(int e00, int e01, int e02, int e10, int e11, int e12,
                                   int e20, int e21, int e22);
        matrix_t m;
        m[0] = e00[ELEM_W-1:0]; m[1] = e01[ELEM_W-1:0]; m[2] = e02[ELEM_W-1:0];
        m[3] = e10[ELEM_W-1:0]; m[4] = e11[ELEM_W-1:0]; m[5] = e12[ELEM_W-1:0];
        m[6] = e20[ELEM_W-1:0]; m[7] = e21[ELEM_W-1:0]; m[8] = e22[ELEM_W-1:0];
        return m;
    endfunction

    // real to Q1.14, rounded and clamped to the nominal range
    function automatic int to_q14(real v);
        int n;
        n = $rtoi(v * ONE_Q + ((v >= 0.0) ? 0.5 : -0.5));
        if (n > ONE_Q)
            n = ONE_Q;
        if (n < -ONE_Q)
            n = -ONE_Q;
        return n;
    endfunction

    function automatic real unit_rand();
        return $itor($urandom_range(0, 65536)) / 32768.0 - 1.0;
    endfunction

    // proper rotation from a random unit quaternion
    function automatic matrix_t random_rotation();
        real qw, qx, qy, qz, nrm;
        do
        begin
            qw = unit_rand();
            qx = unit_rand();
            qy = unit_rand();
            qz = unit_rand();
            nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        end while (nrm < 0.05);
        qw = qw / nrm; qx = qx / nrm; qy = qy / nrm; qz = qz / nrm;
        return mk(to_q14(1.0 - 2.0 * (qy * qy + qz * qz)),
                  to_q14(2.0 * (qx * qy - qz * qw)),
                  to_q14(2.0 * (qx * qz + qy * qw)),
                  to_q14(2.0 * (qx * qy + qz * qw)),
                  to_q14(1.0 - 2.0 * (qx * qx + qz * qz)),
                  to_q14(2.0 * (qy * qz - qx * qw)),
                  to_q14(2.0 * (qx * qz - qy * qw)),
                  to_q14(2.0 * (qy * qz + qx * qw)),
                  to_q14(1.0 - 2.0 * (qx * qx + qy * qy)));
    endfunction

    // arbitrary elements in the nominal range; now and then an off-diagonal
    // pair is made equal so the zero-difference sign rule gets hit
    function automatic matrix_t random_inrange();
        matrix_t m;
        for (int i = 0; i < 9; i++)
            m[i] = 16'($signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
        if ($urandom_range(0, 3) == 0)
            m[7] = m[5];
        if ($urandom_range(0, 3) == 0)
            m[2] = m[6];
        if ($urandom_range(0, 3) == 0)
            m[3] = m[1];
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back requests with random gaps between
    // them; a gap of zero gives long runs with start held high.
    // The request on the bus is predicted at the edge that takes it.
    // ------------------------------------------------------------------
    matrix_t on_bus;
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_quats.push_back(predict_quat(on_bus));
                taken_cnt++;
            end
            if (start && busy)
            begin
                // core pushed back: hold the request as it is
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (matrix_backlog.size() > 0)
            begin
                on_bus = matrix_backlog.pop_front();
                r00 <= on_bus[0]; r01 <= on_bus[1]; r02 <= on_bus[2];
                r10 <= on_bus[3]; r11 <= on_bus[4]; r12 <= on_bus[5];
                r20 <= on_bus[6]; r21 <= on_bus[7]; r22 <= on_bus[8];
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a result for exactly one cycle and cannot be
    // stalled, so every strobe is compared against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && done)
        begin
            got = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
            if (predicted_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%t: result with no request pending: w=%0d x=%0d y=%0d z=%0d",
                             $realtime, got.w, $signed(got.x), $signed(got.y),
                             $signed(got.z));
            end
            else
            begin
                want = predicted_quats.pop_front();
                checked_cnt++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%t: result %0d: expected w=%0d x=%0d y=%0d z=%0d",
                                 $realtime, checked_cnt,
                                 want.w, $signed(want.x), $signed(want.y), $signed(want.z),
                                 ", got w=%0d x=%0d y=%0d z=%0d",
                                 got.w, $signed(got.x), $signed(got.y), $signed(got.z));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, fill the backlog, wait for every request to be
    // taken and every result to come back, then report.
    // ------------------------------------------------------------------
    initial
    begin
        int pick;
        int waited;

        // directed: identity, zero, nominal extremes
        matrix_backlog.push_back(mk(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
        matrix_backlog.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_backlog.push_back(mk(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                    ONE_Q, ONE_Q, ONE_Q));
        matrix_backlog.push_back(mk(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q,
                                    -ONE_Q, -ONE_Q, -ONE_Q));
        // half turns about x, y, z: w collapses to zero
        matrix_backlog.push_back(mk(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        matrix_backlog.push_back(mk(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
        matrix_backlog.push_back(mk(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
        // quarter turns each way about each axis: sign taken from the difference
        matrix_backlog.push_back(mk(ONE_Q, 0, 0, 0, 0, -ONE_Q, 0, ONE_Q, 0));
        matrix_backlog.push_back(mk(ONE_Q, 0, 0, 0, 0, ONE_Q, 0, -ONE_Q, 0));
        matrix_backlog.push_back(mk(0, 0, ONE_Q, 0, ONE_Q, 0, -ONE_Q, 0, 0));
        matrix_backlog.push_back(mk(0, 0, -ONE_Q, 0, ONE_Q, 0, ONE_Q, 0, 0));
        matrix_backlog.push_back(mk(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q));
        matrix_backlog.push_back(mk(0, ONE_Q, 0, -ONE_Q, 0, 0, 0, 0, ONE_Q));
        // zero magnitude with all three differences negative
        matrix_backlog.push_back(mk(ONE_Q, 100, -100, -100, ONE_Q, 100,
                                    100, -100, ONE_Q));
        // full 16-bit extremes, out of the nominal range
        matrix_backlog.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
        matrix_backlog.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
        matrix_backlog.push_back(mk(32767, -32768, -32768, -32768, 32767, -32768,
                                    -32768, -32768, 32767));
        matrix_backlog.push_back(mk(-32768, 32767, 32767, 32767, -32768, 32767,
                                    32767, 32767, -32768));
        // largest possible sum lands on x
        matrix_backlog.push_back(mk(32767, 0, 0, 0, -32768, 0, 0, 1, -32768));
        // sums of exactly -1 for w and x, and exactly +1 for w
        matrix_backlog.push_back(mk(-ONE_Q - 1, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_backlog.push_back(mk(-ONE_Q + 1, 0, 0, 0, 0, 0, 0, 0, 0));
        // alternating bit patterns
        matrix_backlog.push_back(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        matrix_backlog.push_back(mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        directed_cnt = matrix_backlog.size();

        // random: mostly proper rotations, then arbitrary in-range matrices,
        // then raw 16-bit noise that toggles every input bit
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                matrix_backlog.push_back(random_rotation());
                rotation_cnt++;
            end
            else if (pick < 85)
            begin
                matrix_backlog.push_back(random_inrange());
                inrange_cnt++;
            end
            else
            begin
                matrix_backlog.push_back(matrix_t'((9 * ELEM_W)'({$urandom(), $urandom(),
                                                    $urandom(), $urandom(), $urandom()})));
                noise_cnt++;
            end
        end
        total_requests = matrix_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (taken_cnt < total_requests)
            @(posedge clk);
        waited = 0;
        while (predicted_quats.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYC) @(posedge clk);

        if (predicted_quats.size() != 0)
        begin
            $display("%0d predicted results never arrived", predicted_quats.size());
            mismatches += predicted_quats.size();
        end

        $display("Sent %0d matrices: %0d directed, %0d rotations, %0d in-range, %0d raw.",
                 total_requests, directed_cnt, rotation_cnt, inrange_cnt, noise_cnt);
        $display("Checked %0d quaternions, %0d failures.", checked_cnt, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d of %0d requests taken, %0d results checked",
                 taken_cnt, total_requests, checked_cnt);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
